/* rtl/core/cgbs_pkg.sv */
package cgbs_pkg;

  localparam int MAX_BODIES = 32;
  localparam int FRAC_BITS  = 32;
  localparam int QW         = 48;
  localparam int BODY_W     = $clog2(MAX_BODIES);
  localparam int PV_DEPTH   = 3 * MAX_BODIES;
  localparam int PV_AW      = $clog2(PV_DEPTH);
  localparam int MAG_W      = QW + FRAC_BITS;
  localparam int ROOT_W     = MAG_W / 2;
  localparam int CNT_W      = $clog2(MAG_W + 1);
  localparam int SCR_W      = 12;
  localparam int PIX_W      = 16;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;

  localparam int MUL_STEPS  = QW;
  localparam int DIV_STEPS  = MAG_W;
  localparam int SQRT_STEPS = ROOT_W;

  // floor(h / 5) as (h * RECIP5) >> RECIP5_W, exact for 12-bit h
  localparam int RECIP5_W  = 14;
  localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(3277);

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  localparam logic [QW-1:0] Q_MAX     = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN     = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] GRAV_Q    = QW'(64'd0 - ((ONE_Q + 64'd25) / 64'd50));
  localparam logic [QW-1:0] DIST_Q    = QW'(ONE_Q * 64'd16);
  localparam logic [QW-1:0] COLLIDE_Q = QW'((ONE_Q + 64'd5000) / 64'd10000);
  localparam logic [QW-1:0] NEG_ALMOST_Q =
    QW'(64'd0 - ((ONE_Q * 64'd1599 + 64'd50) / 64'd100));
  localparam logic [QW-1:0] HALF_Q    = QW'(ONE_Q / 64'd2);
  localparam logic [QW-1:0] Q_LSB     = QW'(1);

  localparam logic [MAG_W-1:0] MIN_MAG = MAG_W'(1) << (QW - 1);
  localparam logic [MAG_W-1:0] MAX_MAG = MIN_MAG - MAG_W'(1);

  localparam logic [SCR_W-1:0]   WIDTH_RST  = SCR_W'(640);
  localparam logic [SCR_W-1:0]   HEIGHT_RST = SCR_W'(480);
  localparam logic [COUNT_W-1:0] COUNT_RST  = COUNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic          start;
    alu_op_e       op;
    logic [QW-1:0] a;
    logic [QW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] res;
  } alu_rsp_t;

  function automatic logic [QW-1:0] q_mag(input logic [QW-1:0] a);
    return a[QW-1] ? (~a + Q_LSB) : a;
  endfunction

  // saturate a magnitude with sign into the signed Q range
  function automatic logic [QW-1:0] q_sat(input logic [MAG_W-1:0] m, input logic neg);
    logic [QW-1:0] r;
    if (neg) begin
      r = (m > MIN_MAG) ? Q_MIN : (~m[QW-1:0] + Q_LSB);
    end else begin
      r = (m > MAX_MAG) ? Q_MAX : m[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic [QW-1:0] q_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    logic [QW-1:0] r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      r = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] sat_pix(input logic [QW-1:0] v);
    logic [PIX_W-1:0] r;
    if (v[QW-1:PIX_W-1] == '0 || v[QW-1:PIX_W-1] == '1) begin
      r = v[PIX_W-1:0];
    end else begin
      r = v[QW-1] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic on_spot(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                                   input logic [SCR_W-1:0] w, input logic [SCR_W-1:0] h);
    return !x[PIX_W-1] && !y[PIX_W-1] && (x <= PIX_W'(w)) && (y <= PIX_W'(h));
  endfunction

endpackage

/* rtl/core/cgbs_ram.sv */
module cgbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/cgbs_alu.sv */
module cgbs_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cgbs_pkg::alu_req_t req_i,
  output cgbs_pkg::alu_rsp_t rsp_o
);

  localparam int QW     = cgbs_pkg::QW;
  localparam int MAG_W  = cgbs_pkg::MAG_W;
  localparam int ROOT_W = cgbs_pkg::ROOT_W;
  localparam int CNT_W  = cgbs_pkg::CNT_W;

  logic                busy_q, done_q, neg_q;
  cgbs_pkg::alu_op_e   op_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2*QW-1:0]     acc_q;
  logic [QW-1:0]       mb_q;
  logic [MAG_W-1:0]    num_q;
  logic [QW-1:0]       rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+1:0]   srem_q;
  logic [QW-1:0]       res_q;

  logic [QW:0]         mul_sum;
  logic [2*QW-1:0]     mul_acc;
  logic [QW:0]         div_sh;
  logic                div_ge;
  logic [QW:0]         div_rem;
  logic [MAG_W-1:0]    div_num;
  logic [ROOT_W+3:0]   sq_sh, sq_trial, sq_rem;
  logic                sq_ge;
  logic [ROOT_W-1:0]   sq_root;
  logic                last_w;

  // shift-add multiply, one multiplier bit per cycle
  assign mul_sum = {1'b0, acc_q[2*QW-1:QW]} + {1'b0, (mb_q[0] ? num_q[QW-1:0] : '0)};
  assign mul_acc = {mul_sum, acc_q[QW-1:1]};

  // restoring divide, one quotient bit per cycle
  assign div_sh  = {rem_q, num_q[MAG_W-1]};
  assign div_ge  = div_sh >= {1'b0, mb_q};
  assign div_rem = div_ge ? (div_sh - {1'b0, mb_q}) : div_sh;
  assign div_num = {num_q[MAG_W-2:0], div_ge};

  // digit-by-digit square root, two radicand bits per cycle
  assign sq_sh    = {srem_q, num_q[MAG_W-1:MAG_W-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  assign sq_root  = {root_q[ROOT_W-2:0], sq_ge};

  always_comb begin
    unique case (op_q)
      cgbs_pkg::ALU_MUL:  last_w = (cnt_q == CNT_W'(cgbs_pkg::MUL_STEPS - 1));
      cgbs_pkg::ALU_DIV:  last_w = (cnt_q == CNT_W'(cgbs_pkg::DIV_STEPS - 1));
      cgbs_pkg::ALU_SQRT: last_w = (cnt_q == CNT_W'(cgbs_pkg::SQRT_STEPS - 1));
      default:            last_w = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= cgbs_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      // divide by zero finishes right away
      done_q <= busy_q ? last_w :
                (req_i.start && (req_i.op == cgbs_pkg::ALU_DIV) && (req_i.b == '0));
      if (req_i.start && !busy_q) begin
        op_q  <= req_i.op;
        cnt_q <= '0;
        neg_q <= req_i.a[QW-1] ^ req_i.b[QW-1];
        unique case (req_i.op)
          cgbs_pkg::ALU_MUL: begin
            busy_q <= 1'b1;
            acc_q  <= '0;
            num_q  <= MAG_W'(cgbs_pkg::q_mag(req_i.a));
            mb_q   <= cgbs_pkg::q_mag(req_i.b);
          end
          cgbs_pkg::ALU_DIV: begin
            if (req_i.b == '0) begin
              // divide by zero: saturate toward the sign of the dividend, or give zero for a zero dividend
              if (req_i.a == '0) begin
                res_q <= '0;
              end else begin
                res_q <= req_i.a[QW-1] ? cgbs_pkg::Q_MIN : cgbs_pkg::Q_MAX;
              end
            end else begin
              busy_q <= 1'b1;
              rem_q  <= '0;
              num_q  <= {cgbs_pkg::q_mag(req_i.a), {cgbs_pkg::FRAC_BITS{1'b0}}};
              mb_q   <= cgbs_pkg::q_mag(req_i.b);
            end
          end
          default: begin
            busy_q <= 1'b1;
            srem_q <= '0;
            root_q <= '0;
            num_q  <= {req_i.a, {cgbs_pkg::FRAC_BITS{1'b0}}};
          end
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        unique case (op_q)
          cgbs_pkg::ALU_MUL: begin
            acc_q <= mul_acc;
            mb_q  <= mb_q >> 1;
            if (last_w) begin
              res_q <= cgbs_pkg::q_sat(MAG_W'(mul_acc[2*QW-1:cgbs_pkg::FRAC_BITS]), neg_q);
            end
          end
          cgbs_pkg::ALU_DIV: begin
            rem_q <= div_rem[QW-1:0];
            num_q <= div_num;
            if (last_w) begin
              res_q <= cgbs_pkg::q_sat(div_num, neg_q);
            end
          end
          default: begin
            srem_q <= sq_rem[ROOT_W+1:0];
            root_q <= sq_root;
            num_q  <= {num_q[MAG_W-3:0], 2'b00};
            if (last_w) begin
              res_q <= QW'(sq_root);
            end
          end
        endcase
        if (last_w) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* rtl/core/central_gravity_body_stepper.sv */
// Steps up to 32 bodies orbiting a central mass and projects each onto the screen.
// A load request stores one body and returns one result; a tick request steps
// bodies 0..body_count-1 (at most 32) and returns one result per body, last on the
// final one. All multiplies, divides and the square root share one bit-serial unit.
// The block takes no new request until the last result has been taken.
// Configuration writes are accepted every cycle and belong in idle periods.
module central_gravity_body_stepper (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic [cgbs_pkg::BODY_W-1:0]           body_index_i,
  input  logic signed [cgbs_pkg::QW-1:0]        pos_x_i,
  input  logic signed [cgbs_pkg::QW-1:0]        pos_y_i,
  input  logic signed [cgbs_pkg::QW-1:0]        pos_z_i,
  input  logic signed [cgbs_pkg::QW-1:0]        vel_x_i,
  input  logic signed [cgbs_pkg::QW-1:0]        vel_y_i,
  input  logic signed [cgbs_pkg::QW-1:0]        vel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [cgbs_pkg::BODY_W-1:0]           result_body_o,
  output logic signed [cgbs_pkg::PIX_W-1:0]     prev_screen_x_o,
  output logic signed [cgbs_pkg::PIX_W-1:0]     prev_screen_y_o,
  output logic                                  prev_on_screen_o,
  output logic signed [cgbs_pkg::PIX_W-1:0]     screen_x_o,
  output logic signed [cgbs_pkg::PIX_W-1:0]     screen_y_o,
  output logic [cgbs_pkg::PIX_W-1:0]            radius_o,
  output logic                                  on_screen_o,
  output logic                                  last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [cgbs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cgbs_pkg::SCR_W-1:0]            cfg_data_i
);

  localparam int QW      = cgbs_pkg::QW;
  localparam int BODY_W  = cgbs_pkg::BODY_W;
  localparam int PV_AW   = cgbs_pkg::PV_AW;
  localparam int PIX_W   = cgbs_pkg::PIX_W;
  localparam int SCR_W   = cgbs_pkg::SCR_W;
  localparam int COUNT_W = cgbs_pkg::COUNT_W;
  localparam int RECIP_PAD = cgbs_pkg::RECIP5_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ISSUE,
    S_WAIT,
    S_WRITE,
    S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    ST_SQX, ST_SQY, ST_SQZ, ST_SQRT, ST_SS, ST_CUBE, ST_GMUL, ST_GDIV,
    ST_PDX, ST_PMX, ST_PDY, ST_PMY, ST_RAD
  } step_e;

  state_e               state_q;
  step_e                step_q;
  logic [1:0]           cnt_q, comp_q;
  logic                 load_q, out_valid_q;
  logic [BODY_W-1:0]    body_q;
  logic [COUNT_W-1:0]   n_q;
  logic [SCR_W-1:0]     width_q, height_q;
  logic [COUNT_W-1:0]   count_q;

  logic [QW-1:0]        p_q [3];
  logic [QW-1:0]        v_q [3];
  logic [QW-1:0]        r2_q, s_q, tmp_q, cube_q;
  logic [PIX_W-1:0]     x_q, y_q, prev_x_q, prev_y_q, rad_q;

  cgbs_pkg::alu_req_t   alu_req;
  cgbs_pkg::alu_rsp_t   alu_rsp;

  logic [QW-1:0]        dist_w, sum_w, vn_w;
  logic [SCR_W+RECIP_PAD-1:0] h5_prod;
  logic [QW-1:0]        h5_w;
  logic                 rad_zero_w, front_w, last_w;
  logic [PV_AW-1:0]     base_w, pv_addr_w;
  logic [QW-1:0]        pos_rd, vel_rd;
  logic [2*PIX_W-1:0]   spot_rd;
  logic [COUNT_W-1:0]   n_w;
  logic                 out_fire;

  assign dist_w     = cgbs_pkg::q_add(p_q[2], cgbs_pkg::DIST_Q);
  assign rad_zero_w = dist_w[QW-1] || (dist_w == '0);
  assign front_w    = $signed(p_q[2]) > $signed(cgbs_pkg::NEG_ALMOST_Q);
  assign h5_prod    = SCR_W'(height_q) * cgbs_pkg::RECIP5;
  assign h5_w       = QW'(h5_prod[SCR_W+RECIP_PAD-1:RECIP_PAD]);
  assign sum_w      = cgbs_pkg::q_add(r2_q, alu_rsp.res);
  assign vn_w       = cgbs_pkg::q_add(v_q[comp_q], alu_rsp.res);
  assign base_w     = PV_AW'({body_q, 1'b0}) + PV_AW'(body_q);
  assign pv_addr_w  = base_w + PV_AW'(cnt_q);
  assign n_w        = (count_q > COUNT_W'(cgbs_pkg::MAX_BODIES)) ?
                      COUNT_W'(cgbs_pkg::MAX_BODIES) : count_q;
  assign last_w     = load_q || (COUNT_W'(body_q) == n_q - COUNT_W'(1));
  assign out_fire   = out_valid_q && out_ready_i;

  cgbs_ram #(.WIDTH(QW), .DEPTH(cgbs_pkg::PV_DEPTH)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (pv_addr_w),
    .wdata_i (p_q[cnt_q]),
    .raddr_i (pv_addr_w),
    .rdata_o (pos_rd)
  );

  cgbs_ram #(.WIDTH(QW), .DEPTH(cgbs_pkg::PV_DEPTH)) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (pv_addr_w),
    .wdata_i (v_q[cnt_q]),
    .raddr_i (pv_addr_w),
    .rdata_o (vel_rd)
  );

  cgbs_ram #(.WIDTH(2*PIX_W), .DEPTH(cgbs_pkg::MAX_BODIES)) u_spot_ram (
    .clk_i   (clk_i),
    .we_i    (out_fire),
    .waddr_i (body_q),
    .wdata_i ({x_q, y_q}),
    .raddr_i (body_q),
    .rdata_o (spot_rd)
  );

  cgbs_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    alu_req.start = (state_q == S_ISSUE);
    alu_req.op    = cgbs_pkg::ALU_MUL;
    alu_req.a     = p_q[0];
    alu_req.b     = p_q[0];
    unique case (step_q)
      ST_SQX:  ;
      ST_SQY:  begin alu_req.a = p_q[1]; alu_req.b = p_q[1]; end
      ST_SQZ:  begin alu_req.a = p_q[2]; alu_req.b = p_q[2]; end
      ST_SQRT: begin alu_req.op = cgbs_pkg::ALU_SQRT; alu_req.a = r2_q; end
      ST_SS:   begin alu_req.a = s_q; alu_req.b = s_q; end
      ST_CUBE: begin alu_req.a = tmp_q; alu_req.b = s_q; end
      ST_GMUL: begin alu_req.a = p_q[comp_q]; alu_req.b = cgbs_pkg::GRAV_Q; end
      ST_GDIV: begin
        alu_req.op = cgbs_pkg::ALU_DIV; alu_req.a = tmp_q; alu_req.b = cube_q;
      end
      ST_PDX:  begin alu_req.op = cgbs_pkg::ALU_DIV; alu_req.b = dist_w; end
      ST_PMX:  begin alu_req.a = QW'(width_q); alu_req.b = tmp_q; end
      ST_PDY:  begin
        alu_req.op = cgbs_pkg::ALU_DIV; alu_req.a = p_q[1]; alu_req.b = dist_w;
      end
      ST_PMY:  begin alu_req.a = QW'(height_q); alu_req.b = tmp_q; end
      ST_RAD:  begin alu_req.op = cgbs_pkg::ALU_DIV; alu_req.a = h5_w; alu_req.b = dist_w; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= cgbs_pkg::WIDTH_RST;
      height_q <= cgbs_pkg::HEIGHT_RST;
      count_q <= cgbs_pkg::COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cgbs_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        cgbs_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        cgbs_pkg::REG_COUNT:  count_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_SQX;
      cnt_q       <= '0;
      comp_q      <= '0;
      load_q      <= 1'b0;
      out_valid_q <= 1'b0;
      body_q      <= '0;
      n_q         <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q <= '0;
            if (operation_i) begin
              load_q   <= 1'b1;
              body_q   <= body_index_i;
              prev_x_q <= '0;
              prev_y_q <= '0;
              p_q[0] <= pos_x_i; p_q[1] <= pos_y_i; p_q[2] <= pos_z_i;
              v_q[0] <= vel_x_i; v_q[1] <= vel_y_i; v_q[2] <= vel_z_i;
              state_q <= S_WRITE;
            end else begin
              load_q <= 1'b0;
              body_q <= '0;
              n_q    <= n_w;
              if (n_w != '0) begin
                state_q <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          // read data arrives in the cycle after its address is presented
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q != 2'd0) begin
            p_q[cnt_q - 2'd1] <= pos_rd;
            v_q[cnt_q - 2'd1] <= vel_rd;
          end
          if (cnt_q == 2'd1) begin
            prev_x_q <= spot_rd[2*PIX_W-1:PIX_W];
            prev_y_q <= spot_rd[PIX_W-1:0];
          end
          if (cnt_q == 2'd3) begin
            step_q  <= ST_SQX;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            unique case (step_q)
              ST_SQX: begin r2_q <= alu_rsp.res; step_q <= ST_SQY; state_q <= S_ISSUE; end
              ST_SQY: begin r2_q <= sum_w; step_q <= ST_SQZ; state_q <= S_ISSUE; end
              ST_SQZ: begin
                // floor the squared distance to keep the pull finite
                r2_q <= ($signed(sum_w) < $signed(cgbs_pkg::COLLIDE_Q)) ?
                        cgbs_pkg::COLLIDE_Q : sum_w;
                step_q  <= ST_SQRT;
                state_q <= S_ISSUE;
              end
              ST_SQRT: begin s_q <= alu_rsp.res; step_q <= ST_SS; state_q <= S_ISSUE; end
              ST_SS:   begin tmp_q <= alu_rsp.res; step_q <= ST_CUBE; state_q <= S_ISSUE; end
              ST_CUBE: begin
                cube_q <= ($signed(alu_rsp.res) < $signed(cgbs_pkg::Q_LSB)) ?
                          cgbs_pkg::Q_LSB : alu_rsp.res;
                comp_q  <= '0;
                step_q  <= ST_GMUL;
                state_q <= S_ISSUE;
              end
              ST_GMUL: begin tmp_q <= alu_rsp.res; step_q <= ST_GDIV; state_q <= S_ISSUE; end
              ST_GDIV: begin
                v_q[comp_q] <= vn_w;
                p_q[comp_q] <= cgbs_pkg::q_add(p_q[comp_q], vn_w);
                if (comp_q == 2'd2) begin
                  cnt_q   <= '0;
                  state_q <= S_WRITE;
                end else begin
                  comp_q  <= comp_q + 2'd1;
                  step_q  <= ST_GMUL;
                  state_q <= S_ISSUE;
                end
              end
              ST_PDX: begin
                tmp_q   <= cgbs_pkg::q_add(cgbs_pkg::HALF_Q, alu_rsp.res);
                step_q  <= ST_PMX;
                state_q <= S_ISSUE;
              end
              ST_PMX: begin
                x_q     <= cgbs_pkg::sat_pix(alu_rsp.res);
                step_q  <= ST_PDY;
                state_q <= S_ISSUE;
              end
              ST_PDY: begin
                tmp_q   <= cgbs_pkg::q_add(cgbs_pkg::HALF_Q, alu_rsp.res);
                step_q  <= ST_PMY;
                state_q <= S_ISSUE;
              end
              ST_PMY: begin
                y_q <= cgbs_pkg::sat_pix(alu_rsp.res);
                if (rad_zero_w) begin
                  rad_q       <= '0;
                  out_valid_q <= 1'b1;
                  state_q     <= S_EMIT;
                end else begin
                  step_q  <= ST_RAD;
                  state_q <= S_ISSUE;
                end
              end
              ST_RAD: begin
                rad_q <= (alu_rsp.res > QW'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} :
                         alu_rsp.res[PIX_W-1:0];
                out_valid_q <= 1'b1;
                state_q     <= S_EMIT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd2) begin
            if (front_w) begin
              step_q  <= ST_PDX;
              state_q <= S_ISSUE;
            end else begin
              // behind the viewer: park the spot off screen
              x_q <= '1;
              y_q <= '1;
              if (rad_zero_w) begin
                rad_q       <= '0;
                out_valid_q <= 1'b1;
                state_q     <= S_EMIT;
              end else begin
                step_q  <= ST_RAD;
                state_q <= S_ISSUE;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            cnt_q       <= '0;
            if (last_w) begin
              state_q <= S_IDLE;
            end else begin
              body_q  <= body_q + BODY_W'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_body_o    = body_q;
  assign prev_screen_x_o  = prev_x_q;
  assign prev_screen_y_o  = prev_y_q;
  assign prev_on_screen_o = !load_q && cgbs_pkg::on_spot(prev_x_q, prev_y_q, width_q, height_q);
  assign screen_x_o       = x_q;
  assign screen_y_o       = y_q;
  assign radius_o         = rad_q;
  assign on_screen_o      = cgbs_pkg::on_spot(x_q, y_q, width_q, height_q);
  assign last_o           = last_w;

`ifndef SYNTH
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is pending");

  a_alu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(alu_req.start && alu_rsp.busy))
    else $error("arithmetic unit started while busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("block not idle after final result");
`endif

endmodule

/* bench/central_gravity_body_stepper_tb.sv */
`timescale 1ns / 1ps

module central_gravity_body_stepper_tb;

  localparam logic [cgbs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam longint ONE_FX     = 64'sd1 << 32;
  localparam longint FX_MAX     = 64'sh7FFF_FFFF_FFFF;
  localparam longint FX_MIN     = -64'sh8000_0000_0000;
  localparam longint PULL_FX    = -((ONE_FX + 25) / 50);
  localparam longint VIEW_FX    = 16 * ONE_FX;
  localparam longint FLOOR_FX   = (ONE_FX + 5000) / 10000;
  localparam longint BEHIND_FX  = (1599 * ONE_FX + 50) / 100;
  localparam longint HALF_FX    = ONE_FX / 2;
  localparam int     DRAIN_WAIT = 2500;

  typedef struct packed {
    logic [4:0]  body;
    logic [15:0] px;
    logic [15:0] py;
    logic        pon;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] rad;
    logic        on;
    logic        last;
  } body_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [4:0] body_idx = '0;
  logic signed [47:0] px_in = '0, py_in = '0, pz_in = '0;
  logic signed [47:0] vx_in = '0, vy_in = '0, vz_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] r_body;
  logic signed [15:0] r_px, r_py, r_x, r_y;
  logic r_pon, r_on, r_last;
  logic [15:0] r_rad;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cgbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cgbs_pkg::SCR_W-1:0] cfg_data = '0;

  // predictor state
  longint body_pos [32][3];
  longint body_vel [32][3];
  int spot_x [32];
  int spot_y [32];
  int unsigned scr_w = 640, scr_h = 480, step_count = 10;

  body_result_t expected_results [$];
  int mismatches = 0;
  int hold_rx = 0;
  bit rx_free = 1'b0;
  bit tx_free = 1'b0;

  always #6 clk = ~clk;

  central_gravity_body_stepper dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .body_index_i(body_idx),
    .pos_x_i(px_in), .pos_y_i(py_in), .pos_z_i(pz_in),
    .vel_x_i(vx_in), .vel_y_i(vy_in), .vel_z_i(vz_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_body_o(r_body), .prev_screen_x_o(r_px), .prev_screen_y_o(r_py),
    .prev_on_screen_o(r_pon), .screen_x_o(r_x), .screen_y_o(r_y),
    .radius_o(r_rad), .on_screen_o(r_on), .last_o(r_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic logic [127:0] fx_mag(longint a);
    return a < 0 ? 128'(-a) : 128'(a);
  endfunction

  function automatic longint fx_sat(logic [127:0] m, bit neg);
    if (neg) return (m > 128'h8000_0000_0000) ? FX_MIN : -longint'(m[63:0]);
    return (m > 128'(FX_MAX)) ? FX_MAX : longint'(m[63:0]);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    longint s;
    s = a + b;
    return s > FX_MAX ? FX_MAX : (s < FX_MIN ? FX_MIN : s);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return fx_sat((fx_mag(a) * fx_mag(b)) >> 32, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) return a < 0 ? FX_MIN : (a > 0 ? FX_MAX : 0);
    return fx_sat((fx_mag(a) << 32) / fx_mag(b), (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_root(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (n >= 128'(c) * 128'(c)) r = c;
    end
    return longint'(r);
  endfunction

  function automatic int to_column(int unsigned dim, longint u);
    logic [127:0] ip;
    ip = (128'(dim) * fx_mag(u)) >> 32;
    if (u < 0) return ip > 32768 ? -32768 : -int'(ip[31:0]);
    return ip > 32767 ? 32767 : int'(ip[31:0]);
  endfunction

  function automatic void project_body(int b, output int x, output int y);
    longint d;
    if (body_pos[b][2] > -BEHIND_FX) begin
      d = fx_add(body_pos[b][2], VIEW_FX);
      x = to_column(scr_w, fx_add(HALF_FX, fx_div(body_pos[b][0], d)));
      y = to_column(scr_h, fx_add(HALF_FX, fx_div(body_pos[b][1], d)));
    end else begin
      x = -1;
      y = -1;
    end
  endfunction

  function automatic logic [15:0] body_radius(int b);
    longint d;
    logic [127:0] r;
    d = fx_add(body_pos[b][2], VIEW_FX);
    if (d <= 0) return 16'd0;
    r = (128'(scr_h / 5) << 32) / 128'(d);
    return r > 65535 ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic in_window(int x, int y);
    return x >= 0 && y >= 0 && x <= int'(scr_w) && y <= int'(scr_h);
  endfunction

  function automatic void orbit_step(int b);
    longint r2, s, cube, acc;
    r2 = fx_add(fx_add(fx_mul(body_pos[b][0], body_pos[b][0]),
                       fx_mul(body_pos[b][1], body_pos[b][1])),
                fx_mul(body_pos[b][2], body_pos[b][2]));
    if (r2 < FLOOR_FX) r2 = FLOOR_FX;
    s = fx_root(128'(r2) << 32);
    cube = fx_mul(fx_mul(s, s), s);
    if (cube < 1) cube = 1;
    for (int c = 0; c < 3; c++) begin
      acc = fx_div(fx_mul(body_pos[b][c], PULL_FX), cube);
      body_vel[b][c] = fx_add(body_vel[b][c], acc);
      body_pos[b][c] = fx_add(body_pos[b][c], body_vel[b][c]);
    end
  endfunction

  function automatic void predict_spots(logic kind, int idx, longint v [6]);
    body_result_t e;
    int x, y, n;
    if (kind == OP_LOAD) begin
      for (int c = 0; c < 3; c++) begin
        body_pos[idx][c] = v[c];
        body_vel[idx][c] = v[3 + c];
      end
      project_body(idx, x, y);
      spot_x[idx] = x;
      spot_y[idx] = y;
      e = '{5'(idx), 16'd0, 16'd0, 1'b0, 16'(x), 16'(y), body_radius(idx),
            in_window(x, y), 1'b1};
      expected_results.push_back(e);
    end else begin
      n = step_count > 32 ? 32 : step_count;
      for (int b = 0; b < n; b++) begin
        e.body = 5'(b);
        e.px = 16'(spot_x[b]);
        e.py = 16'(spot_y[b]);
        e.pon = in_window(spot_x[b], spot_y[b]);
        orbit_step(b);
        project_body(b, x, y);
        spot_x[b] = x;
        spot_y[b] = y;
        e.x = 16'(x);
        e.y = 16'(y);
        e.rad = body_radius(b);
        e.on = in_window(x, y);
        e.last = (b + 1 == n);
        expected_results.push_back(e);
      end
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    body_result_t a, e;
    if (rst_n && out_valid && out_ready) begin
      a = '{r_body, r_px, r_py, r_pon, r_x, r_y, r_rad, r_on, r_last};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
      end else begin
        e = expected_results.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int stall_left, r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_rx > 0) begin
        out_ready <= 1'b0;
        hold_rx--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_free) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 150);
        end
      end
    end
  end

  task automatic send_request(logic kind, int idx, longint v [6]);
    int r, gap;
    @(negedge clk);
    op <= kind;
    body_idx <= 5'(idx);
    px_in <= 48'(v[0]);
    py_in <= 48'(v[1]);
    pz_in <= 48'(v[2]);
    vx_in <= 48'(v[3]);
    vy_in <= 48'(v[4]);
    vz_in <= 48'(v[5]);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_spots(kind, idx, v);
    r = $urandom_range(0, 99);
    gap = (tx_free || r < 40) ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60));
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic tick();
    longint v [6];
    v = '{default: 0};
    for (int i = 0; i < 6; i++) v[i] = {$urandom, $urandom};
    send_request(OP_TICK, $urandom_range(0, 31), v);
  endtask

  function automatic longint signed_scale(int unsigned hi_shift);
    longint m;
    m = longint'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, hi_shift);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic load_random(int idx);
    longint v [6];
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 6; i++) v[i] = longint'({{16{1'b0}}, $urandom, $urandom} << 16) >>> 16;
    end else begin
      for (int i = 0; i < 3; i++) v[i] = signed_scale(4);
      for (int i = 3; i < 6; i++) v[i] = signed_scale(0) >>> 3;
      if ($urandom_range(0, 9) == 0) v[2] = -VIEW_FX - signed_scale(1);
    end
    send_request(OP_LOAD, idx, v);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [cgbs_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cgbs_pkg::SCR_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cgbs_pkg::REG_WIDTH:  scr_w = val & 12'hFFF;
      cgbs_pkg::REG_HEIGHT: scr_h = val & 12'hFFF;
      cgbs_pkg::REG_COUNT:  step_count = val & 6'h3F;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_ticks();
    longint v [6];
    v = '{FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX};
    send_request(OP_LOAD, 0, v);
    v = '{FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN};
    send_request(OP_LOAD, 1, v);
    // collapse to the origin: tiny radius, tiny cube
    v = '{0, 0, 0, 0, 0, 0};
    send_request(OP_LOAD, 2, v);
    v = '{ONE_FX, ONE_FX, -VIEW_FX, 0, 0, 0};
    send_request(OP_LOAD, 3, v);
    v = '{ONE_FX, -ONE_FX, -BEHIND_FX, 0, 0, ONE_FX};
    send_request(OP_LOAD, 4, v);
    v = '{ONE_FX, -ONE_FX, -BEHIND_FX + 1, 0, 0, 0};
    send_request(OP_LOAD, 5, v);
    v = '{1, 1, 1, 0, 0, 0};
    send_request(OP_LOAD, 6, v);
    for (int b = 7; b < 10; b++) load_random(b);
    tick();
    tick();
  endtask

  task automatic test_screen_extremes();
    wait_idle();
    write_reg(cgbs_pkg::REG_WIDTH, 1);
    write_reg(cgbs_pkg::REG_HEIGHT, 1);
    write_reg(REG_UNUSED, 12'hFFF);
    tick();
    wait_idle();
    write_reg(cgbs_pkg::REG_WIDTH, 4095);
    write_reg(cgbs_pkg::REG_HEIGHT, 4095);
    load_random(8);
    tick();
  endtask

  task automatic test_zero_count();
    wait_idle();
    write_reg(cgbs_pkg::REG_COUNT, 0);
    tick();
    load_random(9);
  endtask

  task automatic test_random();
    wait_idle();
    for (int b = 10; b < 32; b++) load_random(b);
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(cgbs_pkg::REG_WIDTH, ph == 0 ? 1 : $urandom_range(1, 4095));
      write_reg(cgbs_pkg::REG_HEIGHT, ph == 1 ? 4095 : $urandom_range(1, 4095));
      write_reg(cgbs_pkg::REG_COUNT, $urandom_range(1, 6));
      rx_free = (ph == 2);
      tx_free = (ph == 2);
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 9) < 3) load_random($urandom_range(0, 31));
        else tick();
      end
    end
    rx_free = 1'b0;
    tx_free = 1'b0;
  endtask

  task automatic test_full_count();
    wait_idle();
    write_reg(cgbs_pkg::REG_COUNT, 32);
    tick();
    wait_idle();
    write_reg(cgbs_pkg::REG_COUNT, 63);
    tick();
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(cgbs_pkg::REG_COUNT, 4);
    write_reg(cgbs_pkg::REG_WIDTH, 640);
    write_reg(cgbs_pkg::REG_HEIGHT, 480);
    hold_rx = 5000;
    tx_free = 1'b1;
    tick();
    tick();
    load_random(3);
    tick();
    tx_free = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_ticks();
    test_screen_extremes();
    test_zero_count();
    test_random();
    test_full_count();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("central_gravity_body_stepper_tb passed");
    end else begin
      $display("central_gravity_body_stepper_tb failed");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("central_gravity_body_stepper_tb failed");
    $finish;
  end

endmodule
